// ===== design/cpid_pkg.sv =====
// ----------------------------------------------------------------------------
// cpid_pkg
// Shared types, limits and helpers for the clamped PID controller.
// ----------------------------------------------------------------------------
package cpid_pkg;

  localparam int unsigned DATA_W  = 32;
  localparam int unsigned GAIN_W  = 31;
  localparam int unsigned ERR_W   = 33;
  localparam int unsigned DELTA_W = 34;
  localparam int unsigned PROD_W  = 64;
  localparam int unsigned FRAC_W  = 16;
  localparam int unsigned TERM_W  = PROD_W - FRAC_W;
  localparam int unsigned WIDE_W  = 49;
  localparam int unsigned IDX_W   = 3;

  localparam logic signed [DATA_W-1:0] VALUE_LIMIT = 32'sd1073741823;
  localparam logic signed [DATA_W-1:0] P_LIMIT     = 32'sd2147483647;
  localparam logic signed [DATA_W-1:0] D_LIMIT     = 32'sd2147483647;

  typedef enum logic [IDX_W-1:0] {
    REG_GAIN_P       = 3'd0,
    REG_GAIN_I       = 3'd1,
    REG_GAIN_D       = 3'd2,
    REG_INTEGRAL_MAX = 3'd3,
    REG_INTEGRAL_MIN = 3'd4,
    REG_DRIVE_MAX    = 3'd5,
    REG_DRIVE_MIN    = 3'd6
  } cfg_idx_t;

  typedef struct packed {
    logic [GAIN_W-1:0]        gain_p;
    logic [GAIN_W-1:0]        gain_i;
    logic [GAIN_W-1:0]        gain_d;
    logic signed [DATA_W-1:0] integral_max;
    logic signed [DATA_W-1:0] integral_min;
    logic signed [DATA_W-1:0] drive_max;
    logic signed [DATA_W-1:0] drive_min;
  } cfg_t;

  // Raise to lo first, then lower to hi: with inverted bounds hi wins.
  function automatic logic signed [DATA_W-1:0] clamp32(
    input logic signed [WIDE_W-1:0] v,
    input logic signed [DATA_W-1:0] lo,
    input logic signed [DATA_W-1:0] hi
  );
    logic signed [WIDE_W-1:0] t;
    t = v;
    if (t < WIDE_W'(lo)) t = WIDE_W'(lo);
    if (t > WIDE_W'(hi)) t = WIDE_W'(hi);
    return t[DATA_W-1:0];
  endfunction

endpackage

// ===== design/cpid_if.sv =====
// ----------------------------------------------------------------------------
// cpid channel interfaces
// Valid/ready channels for control samples and drive results.
// ----------------------------------------------------------------------------
interface cpid_in_if import cpid_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] setpoint;
  logic signed [DATA_W-1:0] measured;

  modport source (output valid, output setpoint, output measured, input ready);
  modport sink   (input valid, input setpoint, input measured, output ready);
endinterface

interface cpid_out_if import cpid_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] drive;

  modport source (output valid, output drive, input ready);
  modport sink   (input valid, input drive, output ready);
endinterface

// ===== design/cpid_cfg.sv =====
// ----------------------------------------------------------------------------
// cpid_cfg
// Configuration register file: gains and clamp bounds.
// ----------------------------------------------------------------------------
module cpid_cfg import cpid_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [IDX_W-1:0]  cfg_index,
  input  logic [DATA_W-1:0] cfg_wdata,
  output cfg_t              cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        REG_GAIN_P:       cfg_nxt.gain_p       = cfg_wdata[GAIN_W-1:0];
        REG_GAIN_I:       cfg_nxt.gain_i       = cfg_wdata[GAIN_W-1:0];
        REG_GAIN_D:       cfg_nxt.gain_d       = cfg_wdata[GAIN_W-1:0];
        REG_INTEGRAL_MAX: cfg_nxt.integral_max = cfg_wdata;
        REG_INTEGRAL_MIN: cfg_nxt.integral_min = cfg_wdata;
        REG_DRIVE_MAX:    cfg_nxt.drive_max    = cfg_wdata;
        REG_DRIVE_MIN:    cfg_nxt.drive_min    = cfg_wdata;
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gain_p       <= GAIN_W'(65536);
      cfg_r.gain_i       <= '0;
      cfg_r.gain_d       <= '0;
      cfg_r.integral_max <= 32'sh7FFF_FFFF;
      cfg_r.integral_min <= 32'sh8000_0000;
      cfg_r.drive_max    <= 32'sh7FFF_FFFF;
      cfg_r.drive_min    <= 32'sh8000_0000;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== design/cpid_err.sv =====
// ----------------------------------------------------------------------------
// cpid_err
// Input stage: clamps the sample, forms error and change in error.
// ----------------------------------------------------------------------------
module cpid_err import cpid_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      valid_i,
  output logic                      ready_o,
  input  logic signed [DATA_W-1:0]  setpoint,
  input  logic signed [DATA_W-1:0]  measured,
  output logic                      valid_o,
  input  logic                      ready_i,
  output logic signed [ERR_W-1:0]   err,
  output logic signed [DELTA_W-1:0] delta
);

  logic                      valid_r;
  logic signed [ERR_W-1:0]   err_r;
  logic signed [DELTA_W-1:0] delta_r;
  logic signed [ERR_W-1:0]   last_err_r;
  logic signed [DATA_W-1:0]  sp_c;
  logic signed [DATA_W-1:0]  ms_c;
  logic signed [ERR_W-1:0]   err_nxt;
  logic signed [DELTA_W-1:0] delta_nxt;
  logic                      take;

  assign ready_o = !valid_r || ready_i;
  assign take    = valid_i && ready_o;

  always_comb begin
    sp_c      = clamp32(WIDE_W'(setpoint), -VALUE_LIMIT, VALUE_LIMIT);
    ms_c      = clamp32(WIDE_W'(measured), -VALUE_LIMIT, VALUE_LIMIT);
    err_nxt   = ERR_W'(sp_c) - ERR_W'(ms_c);
    delta_nxt = DELTA_W'(err_nxt) - DELTA_W'(last_err_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= 1'b0;
      last_err_r <= '0;
    end else if (take) begin
      valid_r    <= 1'b1;
      last_err_r <= err_nxt;
    end else if (ready_i) begin
      valid_r    <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      err_r   <= err_nxt;
      delta_r <= delta_nxt;
    end
  end

  assign valid_o = valid_r;
  assign err     = err_r;
  assign delta   = delta_r;

endmodule

// ===== design/cpid_mult.sv =====
// ----------------------------------------------------------------------------
// cpid_mult
// Gain stage: three products, floored to Q16.16 by an arithmetic shift.
// ----------------------------------------------------------------------------
module cpid_mult import cpid_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  cfg_t                      cfg,
  input  logic                      valid_i,
  output logic                      ready_o,
  input  logic signed [ERR_W-1:0]   err,
  input  logic signed [DELTA_W-1:0] delta,
  output logic                      valid_o,
  input  logic                      ready_i,
  output logic signed [TERM_W-1:0]  p_raw,
  output logic signed [TERM_W-1:0]  i_raw,
  output logic signed [TERM_W-1:0]  d_raw
);

  logic                     valid_r;
  logic signed [TERM_W-1:0] p_raw_r;
  logic signed [TERM_W-1:0] i_raw_r;
  logic signed [TERM_W-1:0] d_raw_r;
  logic signed [DATA_W-1:0] gp_s;
  logic signed [DATA_W-1:0] gi_s;
  logic signed [DATA_W-1:0] gd_s;
  logic signed [PROD_W-1:0] prod_p;
  logic signed [PROD_W-1:0] prod_i;
  logic signed [PROD_W-1:0] prod_d;
  logic                     take;

  assign ready_o = !valid_r || ready_i;
  assign take    = valid_i && ready_o;

  always_comb begin
    gp_s   = $signed({1'b0, cfg.gain_p});
    gi_s   = $signed({1'b0, cfg.gain_i});
    gd_s   = $signed({1'b0, cfg.gain_d});
    prod_p = PROD_W'(gp_s) * PROD_W'(err);
    prod_i = PROD_W'(gi_s) * PROD_W'(err);
    prod_d = PROD_W'(gd_s) * PROD_W'(delta);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (take) begin
      valid_r <= 1'b1;
    end else if (ready_i) begin
      valid_r <= 1'b0;
    end
  end

  // dropping the low bits of a two's complement product floors it
  always_ff @(posedge clk) begin
    if (take) begin
      p_raw_r <= prod_p[PROD_W-1:FRAC_W];
      i_raw_r <= prod_i[PROD_W-1:FRAC_W];
      d_raw_r <= prod_d[PROD_W-1:FRAC_W];
    end
  end

  assign valid_o = valid_r;
  assign p_raw   = p_raw_r;
  assign i_raw   = i_raw_r;
  assign d_raw   = d_raw_r;

endmodule

// ===== design/cpid_acc.sv =====
// ----------------------------------------------------------------------------
// cpid_acc
// Term stage: clamps P and D, accumulates and clamps the integral.
// ----------------------------------------------------------------------------
module cpid_acc import cpid_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  cfg_t                      cfg,
  input  logic                      valid_i,
  output logic                      ready_o,
  input  logic signed [TERM_W-1:0]  p_raw,
  input  logic signed [TERM_W-1:0]  i_raw,
  input  logic signed [TERM_W-1:0]  d_raw,
  output logic                      valid_o,
  input  logic                      ready_i,
  output logic signed [DATA_W-1:0]  p_term,
  output logic signed [DATA_W-1:0]  i_term,
  output logic signed [DATA_W-1:0]  d_term
);

  logic                     valid_r;
  logic signed [DATA_W-1:0] p_r;
  logic signed [DATA_W-1:0] d_r;
  logic signed [DATA_W-1:0] integ_r;
  logic signed [DATA_W-1:0] integ_nxt;
  logic signed [WIDE_W-1:0] integ_sum;
  logic                     take;

  assign ready_o = !valid_r || ready_i;
  assign take    = valid_i && ready_o;

  always_comb begin
    integ_sum = WIDE_W'(integ_r) + WIDE_W'(i_raw);
    integ_nxt = clamp32(integ_sum, cfg.integral_min, cfg.integral_max);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      integ_r <= '0;
    end else if (take) begin
      valid_r <= 1'b1;
      integ_r <= integ_nxt;
    end else if (ready_i) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      p_r <= clamp32(WIDE_W'(p_raw), -P_LIMIT, P_LIMIT);
      d_r <= clamp32(WIDE_W'(d_raw), -D_LIMIT, D_LIMIT);
    end
  end

  assign valid_o = valid_r;
  assign p_term  = p_r;
  assign i_term  = integ_r;
  assign d_term  = d_r;

endmodule

// ===== design/cpid_out.sv =====
// ----------------------------------------------------------------------------
// cpid_out
// Output stage: sums the three terms and clamps to the drive range.
// ----------------------------------------------------------------------------
module cpid_out import cpid_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  cfg_t                     cfg,
  input  logic                     valid_i,
  output logic                     ready_o,
  input  logic signed [DATA_W-1:0] p_term,
  input  logic signed [DATA_W-1:0] i_term,
  input  logic signed [DATA_W-1:0] d_term,
  output logic                     valid_o,
  input  logic                     ready_i,
  output logic signed [DATA_W-1:0] drive
);

  localparam int unsigned SUM_W = DATA_W + 2;

  logic                     valid_r;
  logic signed [DATA_W-1:0] drive_r;
  logic signed [SUM_W-1:0]  sum;
  logic                     take;

  assign ready_o = !valid_r || ready_i;
  assign take    = valid_i && ready_o;

  assign sum = SUM_W'(p_term) + SUM_W'(i_term) + SUM_W'(d_term);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (take) begin
      valid_r <= 1'b1;
    end else if (ready_i) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      drive_r <= clamp32(WIDE_W'(sum), cfg.drive_min, cfg.drive_max);
    end
  end

  assign valid_o = valid_r;
  assign drive   = drive_r;

endmodule

// ===== design/clamped_pid_controller_unit.sv =====
// ----------------------------------------------------------------------------
// clamped_pid_controller_unit
// PID controller with clamped inputs, terms, integral and drive, Q16.16.
// ----------------------------------------------------------------------------
// A sample is loaded into the error stage when accepted and moves on stage by
// stage; the sink takes the drive result from the last. Throughput: one sample
// per cycle when the sink is ready; four register stages (error, multiply,
// term clamp/integral, sum/clamp) each hold one transaction under backpressure.
// Reset (synchronous, active low) empties the pipeline, clears the previous
// error and the integral, and loads the configuration reset values.
module clamped_pid_controller_unit import cpid_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  cpid_in_if.sink           in_ch,
  cpid_out_if.source        out_ch,
  input  logic              cfg_we,
  input  logic [IDX_W-1:0]  cfg_index,
  input  logic [DATA_W-1:0] cfg_wdata
);

  cfg_t cfg;

  logic                      s1_valid;
  logic                      s1_ready;
  logic signed [ERR_W-1:0]   s1_err;
  logic signed [DELTA_W-1:0] s1_delta;

  logic                      s2_valid;
  logic                      s2_ready;
  logic signed [TERM_W-1:0]  s2_p;
  logic signed [TERM_W-1:0]  s2_i;
  logic signed [TERM_W-1:0]  s2_d;

  logic                      s3_valid;
  logic                      s3_ready;
  logic signed [DATA_W-1:0]  s3_p;
  logic signed [DATA_W-1:0]  s3_i;
  logic signed [DATA_W-1:0]  s3_d;

  cpid_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  cpid_err u_err (
    .clk      (clk),
    .rst_n    (rst_n),
    .valid_i  (in_ch.valid),
    .ready_o  (in_ch.ready),
    .setpoint (in_ch.setpoint),
    .measured (in_ch.measured),
    .valid_o  (s1_valid),
    .ready_i  (s1_ready),
    .err      (s1_err),
    .delta    (s1_delta)
  );

  cpid_mult u_mult (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .valid_i (s1_valid),
    .ready_o (s1_ready),
    .err     (s1_err),
    .delta   (s1_delta),
    .valid_o (s2_valid),
    .ready_i (s2_ready),
    .p_raw   (s2_p),
    .i_raw   (s2_i),
    .d_raw   (s2_d)
  );

  cpid_acc u_acc (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .valid_i (s2_valid),
    .ready_o (s2_ready),
    .p_raw   (s2_p),
    .i_raw   (s2_i),
    .d_raw   (s2_d),
    .valid_o (s3_valid),
    .ready_i (s3_ready),
    .p_term  (s3_p),
    .i_term  (s3_i),
    .d_term  (s3_d)
  );

  cpid_out u_out (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .valid_i (s3_valid),
    .ready_o (s3_ready),
    .p_term  (s3_p),
    .i_term  (s3_i),
    .d_term  (s3_d),
    .valid_o (out_ch.valid),
    .ready_i (out_ch.ready),
    .drive   (out_ch.drive)
  );

endmodule
